// ===== sv/ihf_pkg.sv =====
// Shared types, codes and constants for the IPv4 receive header filter.
// Depends on nothing; every other file refers to it by scoped names.
package ihf_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  // Five 16-bit words summed need three extra bits.
  localparam int unsigned PART_W     = WORD_W + 3;
  localparam int unsigned SUM_W      = PART_W + 1;
  localparam int unsigned FOLD_W     = WORD_W + 1;

  localparam logic [15:0] HDR_BYTES      = 16'd20;
  localparam logic [15:0] ICMP_MIN_TOTAL = 16'd28;  // header plus 8 data bytes
  localparam logic [15:0] TCP_MIN_TOTAL  = 16'd40;  // header plus 20 data bytes
  localparam logic [15:0] FRAG_BITS      = 16'h3FFF;
  localparam logic [15:0] WORD_ONES      = 16'hFFFF;
  localparam logic [31:0] ALL_ONES_ADDR  = 32'hFFFF_FFFF;
  localparam logic [7:0]  LOOP_NET       = 8'd127;
  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  IP_IHL         = 4'd5;

  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Register indexes as seen on the configuration port (paddr[2]).
  localparam logic REG_LOCAL_ADDR  = 1'b0;
  localparam logic REG_SUBNET_MASK = 1'b1;

  typedef enum logic [1:0] {
    DLV_NONE = 2'd0,
    DLV_ICMP = 2'd1,
    DLV_TCP  = 2'd2,
    DLV_UDP  = 2'd3
  } deliver_t;

  typedef enum logic [3:0] {
    DROP_NONE     = 4'd0,
    DROP_SHORT    = 4'd1,
    DROP_VERSION  = 4'd2,
    DROP_IHL      = 4'd3,
    DROP_CHECKSUM = 4'd4,
    DROP_FRAGMENT = 4'd5,
    DROP_SPOOF    = 4'd6,
    DROP_ADDRESS  = 4'd7,
    DROP_LENGTH   = 4'd8,
    DROP_PROTOCOL = 4'd9
  } drop_t;

  // Outcome of every check except the checksum, computed in the first stage.
  typedef struct packed {
    logic     short_buf;
    logic     bad_version;
    logic     bad_ihl;
    logic     fragment;
    logic     spoof;
    logic     addr_ok;
    logic     bad_length;
    deliver_t deliver;
  } chk_t;

  typedef struct packed {
    logic                valid;
    chk_t                chk;
    logic [PART_W-1:0]   sum_a;
    logic [PART_W-1:0]   sum_b;
    logic [WORD_W-1:0]   plen;
  } s1_t;

  typedef struct packed {
    logic                valid;
    chk_t                chk;
    logic [FOLD_W-1:0]   fold;
    logic [WORD_W-1:0]   plen;
  } s2_t;

endpackage

// ===== sv/ihf_cfg_regs.sv =====
// APB-style register file holding the local address and the subnet mask.
// Depends on ihf_pkg for widths and register indexes.
module ihf_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ihf_pkg::PADDR_W-1:0]  paddr,
  input  logic [ihf_pkg::PDATA_W-1:0]  pwdata,
  output logic [ihf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [ihf_pkg::ADDR_W-1:0]   local_addr,
  output logic [ihf_pkg::ADDR_W-1:0]   subnet_mask
);

  logic [ihf_pkg::ADDR_W-1:0] local_addr_r, local_addr_nxt;
  logic [ihf_pkg::ADDR_W-1:0] subnet_mask_r, subnet_mask_nxt;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    local_addr_nxt  = local_addr_r;
    subnet_mask_nxt = subnet_mask_r;
    if (wr_en) begin
      case (paddr[2])
        ihf_pkg::REG_LOCAL_ADDR:  local_addr_nxt  = pwdata;
        ihf_pkg::REG_SUBNET_MASK: subnet_mask_nxt = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r  <= '0;
      subnet_mask_r <= '0;
    end else begin
      local_addr_r  <= local_addr_nxt;
      subnet_mask_r <= subnet_mask_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      ihf_pkg::REG_LOCAL_ADDR:  prdata = local_addr_r;
      ihf_pkg::REG_SUBNET_MASK: prdata = subnet_mask_r;
      default:                  prdata = '0;
    endcase
  end

  assign local_addr  = local_addr_r;
  assign subnet_mask = subnet_mask_r;

endmodule

// ===== sv/ihf_classify.sv =====
// First pipeline stage: field checks, address filters and two partial checksum sums.
// Depends on ihf_pkg for types and constants.
module ihf_classify (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [7:0]                 version_and_length,
  input  logic [7:0]                 service_byte,
  input  logic [15:0]                total_length,
  input  logic [15:0]                ident,
  input  logic [15:0]                flags_fragment,
  input  logic [7:0]                 time_to_live,
  input  logic [7:0]                 protocol,
  input  logic [15:0]                header_checksum,
  input  logic [31:0]                source_addr,
  input  logic [31:0]                dest_addr,
  input  logic                       from_wire,
  input  logic [15:0]                buffer_length,
  input  logic [ihf_pkg::ADDR_W-1:0] local_addr,
  input  logic [ihf_pkg::ADDR_W-1:0] subnet_mask,
  output ihf_pkg::s1_t               s1
);

  ihf_pkg::s1_t s1_r, s1_nxt;
  logic         la_set;
  logic         src_loop;
  logic         dst_loop;
  logic         dst_subnet_bc;

  assign la_set        = (local_addr != '0);
  assign src_loop      = (source_addr[31:24] == ihf_pkg::LOOP_NET);
  assign dst_loop      = (dest_addr[31:24] == ihf_pkg::LOOP_NET);
  assign dst_subnet_bc = la_set && (subnet_mask != '0) &&
                         (dest_addr == (local_addr | ~subnet_mask));

  always_comb begin
    s1_nxt.valid           = in_valid;
    s1_nxt.chk.short_buf   = (buffer_length < ihf_pkg::HDR_BYTES);
    s1_nxt.chk.bad_version = (version_and_length[7:4] != ihf_pkg::IP_VERSION);
    s1_nxt.chk.bad_ihl     = (version_and_length[3:0] != ihf_pkg::IP_IHL);
    s1_nxt.chk.fragment    = ((flags_fragment & ihf_pkg::FRAG_BITS) != '0);
    s1_nxt.chk.spoof       = from_wire &&
                             (src_loop || dst_loop || (la_set && source_addr == local_addr));
    s1_nxt.chk.addr_ok     = (la_set && dest_addr == local_addr) || dst_loop ||
                             (dest_addr == ihf_pkg::ALL_ONES_ADDR) || dst_subnet_bc;
    // The buffer holds at least a header whenever this flag matters, so the
    // payload fits exactly when the total length does not exceed the buffer.
    s1_nxt.chk.bad_length  = (total_length < ihf_pkg::HDR_BYTES) ||
                             (total_length > buffer_length);
    if (protocol == ihf_pkg::PROTO_ICMP && total_length >= ihf_pkg::ICMP_MIN_TOTAL) begin
      s1_nxt.chk.deliver = ihf_pkg::DLV_ICMP;
    end else if (protocol == ihf_pkg::PROTO_TCP &&
                 total_length >= ihf_pkg::TCP_MIN_TOTAL) begin
      s1_nxt.chk.deliver = ihf_pkg::DLV_TCP;
    end else if (protocol == ihf_pkg::PROTO_UDP) begin
      s1_nxt.chk.deliver = ihf_pkg::DLV_UDP;
    end else begin
      s1_nxt.chk.deliver = ihf_pkg::DLV_NONE;
    end
    s1_nxt.sum_a = ihf_pkg::PART_W'({version_and_length, service_byte})
                 + ihf_pkg::PART_W'(total_length)
                 + ihf_pkg::PART_W'(ident)
                 + ihf_pkg::PART_W'(flags_fragment)
                 + ihf_pkg::PART_W'({time_to_live, protocol});
    s1_nxt.sum_b = ihf_pkg::PART_W'(header_checksum)
                 + ihf_pkg::PART_W'(source_addr[31:16])
                 + ihf_pkg::PART_W'(source_addr[15:0])
                 + ihf_pkg::PART_W'(dest_addr[31:16])
                 + ihf_pkg::PART_W'(dest_addr[15:0]);
    s1_nxt.plen  = total_length - ihf_pkg::HDR_BYTES;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.chk   <= s1_nxt.chk;
    s1_r.sum_a <= s1_nxt.sum_a;
    s1_r.sum_b <= s1_nxt.sum_b;
    s1_r.plen  <= s1_nxt.plen;
  end

  assign s1 = s1_r;

endmodule

// ===== sv/ihf_csum_fold.sv =====
// Second pipeline stage: joins the partial sums and does the first carry fold.
// Depends on ihf_pkg for stage types and widths.
module ihf_csum_fold (
  input  logic         clk,
  input  logic         rst_n,
  input  ihf_pkg::s1_t s1,
  output ihf_pkg::s2_t s2
);

  ihf_pkg::s2_t             s2_r, s2_nxt;
  logic [ihf_pkg::SUM_W-1:0] sum;

  assign sum = ihf_pkg::SUM_W'(s1.sum_a) + ihf_pkg::SUM_W'(s1.sum_b);

  always_comb begin
    s2_nxt.valid = s1.valid;
    s2_nxt.chk   = s1.chk;
    s2_nxt.plen  = s1.plen;
    s2_nxt.fold  = ihf_pkg::FOLD_W'(sum[ihf_pkg::WORD_W-1:0])
                 + ihf_pkg::FOLD_W'(sum[ihf_pkg::SUM_W-1:ihf_pkg::WORD_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.chk  <= s2_nxt.chk;
    s2_r.fold <= s2_nxt.fold;
    s2_r.plen <= s2_nxt.plen;
  end

  assign s2 = s2_r;

endmodule

// ===== sv/ihf_verdict.sv =====
// Third pipeline stage: last carry fold, checksum test and the drop priority.
// Depends on ihf_pkg for stage types and result codes.
module ihf_verdict (
  input  logic          clk,
  input  logic          rst_n,
  input  ihf_pkg::s2_t  s2,
  output logic          out_valid,
  output logic [1:0]    out_deliver_to,
  output logic [3:0]    out_drop_reason,
  output logic [15:0]   out_payload_length
);

  logic [ihf_pkg::FOLD_W-1:0] fold2;
  logic                       csum_ok;
  logic                       valid_r;
  ihf_pkg::deliver_t          deliver_r, deliver_nxt;
  ihf_pkg::drop_t             reason_r, reason_nxt;
  logic [15:0]                plen_r, plen_nxt;

  // One more fold cannot carry again: the first fold is at most 0x10007.
  assign fold2   = ihf_pkg::FOLD_W'(s2.fold[ihf_pkg::WORD_W-1:0])
                 + ihf_pkg::FOLD_W'(s2.fold[ihf_pkg::WORD_W]);
  assign csum_ok = (fold2 == ihf_pkg::FOLD_W'(ihf_pkg::WORD_ONES));

  always_comb begin
    deliver_nxt = ihf_pkg::DLV_NONE;
    plen_nxt    = '0;
    if (s2.chk.short_buf) begin
      reason_nxt = ihf_pkg::DROP_SHORT;
    end else if (s2.chk.bad_version) begin
      reason_nxt = ihf_pkg::DROP_VERSION;
    end else if (s2.chk.bad_ihl) begin
      reason_nxt = ihf_pkg::DROP_IHL;
    end else if (!csum_ok) begin
      reason_nxt = ihf_pkg::DROP_CHECKSUM;
    end else if (s2.chk.fragment) begin
      reason_nxt = ihf_pkg::DROP_FRAGMENT;
    end else if (s2.chk.spoof) begin
      reason_nxt = ihf_pkg::DROP_SPOOF;
    end else if (!s2.chk.addr_ok) begin
      reason_nxt = ihf_pkg::DROP_ADDRESS;
    end else if (s2.chk.bad_length) begin
      reason_nxt = ihf_pkg::DROP_LENGTH;
    end else begin
      plen_nxt = s2.plen;
      if (s2.chk.deliver == ihf_pkg::DLV_NONE) begin
        reason_nxt = ihf_pkg::DROP_PROTOCOL;
      end else begin
        reason_nxt  = ihf_pkg::DROP_NONE;
        deliver_nxt = s2.chk.deliver;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s2.valid;
    end
    deliver_r <= deliver_nxt;
    reason_r  <= reason_nxt;
    plen_r    <= plen_nxt;
  end

  assign out_valid          = valid_r;
  assign out_deliver_to     = deliver_r;
  assign out_drop_reason    = reason_r;
  assign out_payload_length = plen_r;

endmodule

// ===== sv/ipv4_rx_header_filter_top.sv =====
// Top level of the IPv4 receive header filter: config registers and a three-stage pipeline.
// Depends on ihf_pkg, ihf_cfg_regs, ihf_classify, ihf_csum_fold and ihf_verdict.
//
//  Channel   Ports                          Transfer happens when
//  --------  -----------------------------  ---------------------------------
//  input     start, busy, in_*              start high and busy low at clk
//  result    out_valid, out_*               out_valid high for one cycle
//  config    psel, penable, pwrite, paddr,  psel, penable, pwrite, pready high
//            pwdata, prdata, pready
//
// A new header may be started in every cycle, so the block sustains one
// header per clock. Between the start transfer and the out_valid strobe lie
// the three pipeline registers: checks and partial checksum sums, sum join
// with the first carry fold, and the last fold with the drop priority. busy
// is tied low. The synchronous active-low reset clears the stage valid bits
// and both configuration registers; payload registers are not reset. The
// receiver cannot stall, so nothing ever waits inside the pipeline.
module ipv4_rx_header_filter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [7:0]                   in_version_and_length,
  input  logic [7:0]                   in_service_byte,
  input  logic [15:0]                  in_total_length,
  input  logic [15:0]                  in_ident,
  input  logic [15:0]                  in_flags_fragment,
  input  logic [7:0]                   in_time_to_live,
  input  logic [7:0]                   in_protocol,
  input  logic [15:0]                  in_header_checksum,
  input  logic [31:0]                  in_source_addr,
  input  logic [31:0]                  in_dest_addr,
  input  logic                         in_from_wire,
  input  logic [15:0]                  in_buffer_length,
  // Result channel.
  output logic                         out_valid,
  output logic [1:0]                   out_deliver_to,
  output logic [3:0]                   out_drop_reason,
  output logic [15:0]                  out_payload_length,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ihf_pkg::PADDR_W-1:0]  paddr,
  input  logic [ihf_pkg::PDATA_W-1:0]  pwdata,
  output logic [ihf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [ihf_pkg::ADDR_W-1:0] local_addr;
  logic [ihf_pkg::ADDR_W-1:0] subnet_mask;
  logic                       in_transfer;
  ihf_pkg::s1_t               s1;
  ihf_pkg::s2_t               s2;

  // The pipeline never holds an item back, so a start is always taken.
  assign busy        = 1'b0;
  assign in_transfer = start & ~busy;

  ihf_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .local_addr  (local_addr),
    .subnet_mask (subnet_mask)
  );

  // Stage one: all field and address checks, plus the checksum split into two
  // five-word partial sums.
  ihf_classify u_classify (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_transfer),
    .version_and_length (in_version_and_length),
    .service_byte       (in_service_byte),
    .total_length       (in_total_length),
    .ident              (in_ident),
    .flags_fragment     (in_flags_fragment),
    .time_to_live       (in_time_to_live),
    .protocol           (in_protocol),
    .header_checksum    (in_header_checksum),
    .source_addr        (in_source_addr),
    .dest_addr          (in_dest_addr),
    .from_wire          (in_from_wire),
    .buffer_length      (in_buffer_length),
    .local_addr         (local_addr),
    .subnet_mask        (subnet_mask),
    .s1                 (s1)
  );

  // Stage two: full ones'-complement sum and its first end-around carry.
  ihf_csum_fold u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .s2    (s2)
  );

  // Stage three: final carry, checksum test, and the first failing check
  // picks the drop reason.
  ihf_verdict u_verdict (
    .clk                (clk),
    .rst_n              (rst_n),
    .s2                 (s2),
    .out_valid          (out_valid),
    .out_deliver_to     (out_deliver_to),
    .out_drop_reason    (out_drop_reason),
    .out_payload_length (out_payload_length)
  );

endmodule
